### hdl/lru_writeback_register_cache_defines.svh
// assertion macros for the lru writeback register cache
// used by the top level; expects clk_i and rst_ni in scope
`ifndef LRU_WRITEBACK_REGISTER_CACHE_DEFINES_SVH
`define LRU_WRITEBACK_REGISTER_CACHE_DEFINES_SVH

// property holds at every clock edge outside reset
`define RWRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rwrc assertion failed");

// consequent holds in the cycle after the antecedent
`define RWRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rwrc assertion failed");

`endif

### hdl/rwrc_pkg.sv
// shared types and codes of the lru writeback register cache
// no dependencies
package rwrc_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned OFF_W  = 16;
  localparam int unsigned REG_W  = 4;
  localparam int unsigned IMM_W  = 64;
  localparam int unsigned ACT_W  = 3;

  // operation codes on the request channel
  typedef enum logic [MODE_W-1:0] {
    MODE_LET   = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_STORE = 2'd2,
    MODE_FLUSH = 2'd3
  } mode_e;

  // result action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_DONE = 3'd0,
    ACT_WB   = 3'd1,
    ACT_READ = 3'd2,
    ACT_SET  = 3'd3,
    ACT_ERR  = 3'd4
  } action_e;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_LET,
    OP_LOAD,
    OP_STORE,
    OP_FLUSH,
    OP_ERR
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [OFF_W-1:0]   field_offset;
    logic [REG_W-1:0]   reg_in;
    logic [IMM_W-1:0]   imm_value;
  } desc_t;

endpackage

### hdl/rwrc_in_if.sv
// request channel of the lru writeback register cache
// depends on rwrc_pkg
interface rwrc_in_if import rwrc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [OFF_W-1:0]   field_offset;
  logic [REG_W-1:0]   reg_in;
  logic [IMM_W-1:0]   imm_value;

  modport source (output valid, mode, field_offset, reg_in, imm_value, input ready);
  modport sink (input valid, mode, field_offset, reg_in, imm_value, output ready);
endinterface

### hdl/rwrc_out_if.sv
// result channel of the lru writeback register cache
// depends on rwrc_pkg
interface rwrc_out_if import rwrc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [REG_W-1:0]   reg_out;
  logic [OFF_W-1:0]   offset_out;
  logic [IMM_W-1:0]   value_out;
  logic               last;

  modport source (output valid, action, reg_out, offset_out, value_out, last, input ready);
  modport sink (input valid, action, reg_out, offset_out, value_out, last, output ready);
endinterface

### hdl/rwrc_front.sv
// front part: accepts requests, classifies them and queues them
// depends on rwrc_pkg and rwrc_in_if
module rwrc_front import rwrc_pkg::*; #(
  parameter int unsigned NUM_REGS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rwrc_in_if.sink    in_i,
  output desc_t      desc_o,
  output logic       desc_valid_o,
  input  logic       desc_ready_i
);

  localparam int unsigned QDepth = 2;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  desc_t             q_mem [QDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  desc_t             desc_in;
  logic              push, pop;

  // classify the incoming request
  always_comb begin
    desc_in.field_offset = in_i.field_offset;
    desc_in.reg_in       = in_i.reg_in;
    desc_in.imm_value    = in_i.imm_value;
    case (mode_e'(in_i.mode))
      MODE_LET:   desc_in.op = OP_LET;
      MODE_LOAD:  desc_in.op = OP_LOAD;
      MODE_STORE: begin
        if ({1'b0, in_i.reg_in} >= (REG_W + 1)'(NUM_REGS)) desc_in.op = OP_ERR;
        else desc_in.op = OP_STORE;
      end
      MODE_FLUSH: desc_in.op = OP_FLUSH;
      default:    desc_in.op = OP_FLUSH;
    endcase
  end

  // queue handshakes
  assign in_i.ready   = (cnt_q != CntW'(QDepth));
  assign desc_valid_o = (cnt_q != '0);
  assign desc_o       = q_mem[rd_q];
  assign push         = in_i.valid && in_i.ready;
  assign pop          = desc_valid_o && desc_ready_i;

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= desc_in;
  end

endmodule

### hdl/rwrc_back.sv
// back part: tag match, recency update, writeback sequencing, result register
// depends on rwrc_pkg and rwrc_out_if
module rwrc_back import rwrc_pkg::*; #(
  parameter int unsigned NUM_REGS    = 8,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  desc_t      desc_i,
  input  logic       desc_valid_i,
  output logic       desc_ready_o,
  rwrc_out_if.source out_o
);

  localparam int unsigned IdxW = $clog2(NUM_REGS);
  localparam int unsigned OffW = (OFFSET_BITS < OFF_W) ? OFFSET_BITS : OFF_W;

  typedef logic [NUM_REGS-1:0][IdxW-1:0] rec_t;
  typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_FINAL, S_FLUSH} state_e;

  state_e              state_q;
  desc_t               desc_q;
  logic [NUM_REGS-1:0] match_q;
  logic [IdxW-1:0]     tgt_q, cnt_q;
  logic                hit_q;
  rec_t                rec_q;
  logic [NUM_REGS-1:0] valid_q, dirty_q;
  logic [OffW-1:0]     off_q [NUM_REGS];

  logic                out_valid_q, last_q;
  logic [ACT_W-1:0]    act_q;
  logic [REG_W-1:0]    reg_q;
  logic [OFF_W-1:0]    offo_q;
  logic [IMM_W-1:0]    val_q;

  logic [NUM_REGS-1:0] match_in;
  logic [OffW-1:0]     off_in, new_off, rd_off;
  logic                emit_ok, hit, need_wb, fin_hit, do_update, load_out;
  logic [IdxW-1:0]     victim, hit_idx, tgt, fin_tgt, rd_idx;
  rec_t                rec_front;
  action_e             fin_act;
  logic [REG_W-1:0]    fin_reg;
  logic [OFF_W-1:0]    fin_off;
  logic [IMM_W-1:0]    fin_val;

  // move entry e to the front of the recency list
  function automatic rec_t to_front(rec_t rec, logic [IdxW-1:0] e);
    rec_t res;
    logic found;
    res   = rec;
    found = 1'b0;
    for (int i = NUM_REGS - 1; i >= 1; i--) begin
      found  = found | (rec[i] == e);
      res[i] = found ? rec[i-1] : rec[i];
    end
    res[0] = e;
    return res;
  endfunction

  assign off_in  = desc_i.field_offset[OffW-1:0];
  assign new_off = desc_q.field_offset[OffW-1:0];
  assign emit_ok = !out_valid_q || out_o.ready;
  assign victim  = rec_q[NUM_REGS-1];
  assign desc_ready_o = (state_q == S_IDLE);

  // a new result enters the output register this cycle
  assign load_out = emit_ok && (((state_q == S_DECIDE) && (desc_q.op != OP_FLUSH)) ||
                                (state_q == S_FINAL) ||
                                ((state_q == S_FLUSH) && dirty_q[cnt_q]));

  // tag compare on every entry, registered for the decide cycle
  always_comb begin
    for (int e = 0; e < NUM_REGS; e++) begin
      match_in[e] = valid_q[e] && (off_q[e] == off_in);
    end
  end

  // first matching entry in recency order
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int p = NUM_REGS - 1; p >= 0; p--) begin
      if (match_q[rec_q[p]]) begin
        hit     = 1'b1;
        hit_idx = rec_q[p];
      end
    end
  end

  // target entry and writeback need
  always_comb begin
    tgt = '0;
    case (desc_q.op)
      OP_LET:   tgt = victim;
      OP_LOAD:  tgt = hit ? hit_idx : victim;
      OP_STORE: tgt = desc_q.reg_in[IdxW-1:0];
      default:  tgt = '0;
    endcase
    rd_idx = (state_q == S_FLUSH) ? cnt_q : tgt;
    rd_off = off_q[rd_idx];
    case (desc_q.op)
      OP_LET:   need_wb = dirty_q[tgt];
      OP_LOAD:  need_wb = !hit && dirty_q[tgt];
      OP_STORE: need_wb = dirty_q[tgt] && (rd_off != new_off);
      default:  need_wb = 1'b0;
    endcase
  end

  // final result of the request and its recency update
  always_comb begin
    fin_tgt   = (state_q == S_FINAL) ? tgt_q : tgt;
    fin_hit   = (state_q == S_FINAL) ? hit_q : hit;
    rec_front = to_front(rec_q, fin_tgt);
    fin_reg   = REG_W'(fin_tgt);
    fin_off   = '0;
    fin_val   = '0;
    do_update = 1'b1;
    case (desc_q.op)
      OP_LET: begin
        fin_act = ACT_SET;
        fin_val = desc_q.imm_value;
      end
      OP_LOAD: begin
        if (fin_hit) begin
          fin_act = ACT_DONE;
        end else begin
          fin_act = ACT_READ;
          fin_off = OFF_W'(new_off);
        end
      end
      OP_STORE: fin_act = ACT_DONE;
      OP_ERR: begin
        fin_act   = ACT_ERR;
        fin_reg   = desc_q.reg_in;
        do_update = 1'b0;
      end
      default: begin
        fin_act   = ACT_DONE;
        fin_reg   = '0;
        do_update = 1'b0;
      end
    endcase
  end

  // sequencer, cache state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      dirty_q     <= '0;
      cnt_q       <= '0;
      tgt_q       <= '0;
      hit_q       <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        rec_q[i] <= IdxW'(i);
        off_q[i] <= '0;
      end
    end else begin
      if (load_out) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (desc_valid_i) begin
            desc_q  <= desc_i;
            match_q <= match_in;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (desc_q.op == OP_FLUSH) begin
            cnt_q   <= '0;
            state_q <= S_FLUSH;
          end else if (emit_ok) begin
            if (need_wb) begin
              act_q        <= ACT_WB;
              reg_q        <= REG_W'(tgt);
              offo_q       <= OFF_W'(rd_off);
              val_q        <= '0;
              last_q       <= 1'b0;
              dirty_q[tgt] <= 1'b0;
              tgt_q        <= tgt;
              hit_q        <= hit;
              state_q      <= S_FINAL;
            end else begin
              act_q   <= fin_act;
              reg_q   <= fin_reg;
              offo_q  <= fin_off;
              val_q   <= fin_val;
              last_q  <= 1'b1;
              state_q <= S_IDLE;
              if (do_update) begin
                rec_q <= rec_front;
                case (desc_q.op)
                  OP_LET:  valid_q[fin_tgt] <= 1'b0;
                  OP_LOAD: begin
                    if (!fin_hit) begin
                      valid_q[fin_tgt] <= 1'b1;
                      off_q[fin_tgt]   <= new_off;
                    end
                  end
                  OP_STORE: begin
                    valid_q[fin_tgt] <= 1'b1;
                    dirty_q[fin_tgt] <= 1'b1;
                    off_q[fin_tgt]   <= new_off;
                  end
                  default: ;
                endcase
              end
            end
          end
        end
        S_FINAL: begin
          if (emit_ok) begin
            act_q       <= fin_act;
            reg_q       <= fin_reg;
            offo_q      <= fin_off;
            val_q       <= fin_val;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
            if (do_update) begin
              rec_q <= rec_front;
              case (desc_q.op)
                OP_LET:  valid_q[fin_tgt] <= 1'b0;
                OP_LOAD: begin
                  if (!fin_hit) begin
                    valid_q[fin_tgt] <= 1'b1;
                    off_q[fin_tgt]   <= new_off;
                  end
                end
                OP_STORE: begin
                  valid_q[fin_tgt] <= 1'b1;
                  dirty_q[fin_tgt] <= 1'b1;
                  off_q[fin_tgt]   <= new_off;
                end
                default: ;
              endcase
            end
          end
        end
        S_FLUSH: begin
          // one entry a cycle, writeback where dirty; a dirty entry waits until the output register is free
          if (!dirty_q[cnt_q] || emit_ok) begin
            if (dirty_q[cnt_q]) begin
              act_q          <= ACT_WB;
              reg_q          <= REG_W'(cnt_q);
              offo_q         <= OFF_W'(rd_off);
              val_q          <= '0;
              last_q         <= 1'b0;
              dirty_q[cnt_q] <= 1'b0;
            end
            if (cnt_q == IdxW'(NUM_REGS - 1)) state_q <= S_FINAL;
            else cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result channel
  assign out_o.valid      = out_valid_q;
  assign out_o.action     = act_q;
  assign out_o.reg_out    = reg_q;
  assign out_o.offset_out = offo_q;
  assign out_o.value_out  = val_q;
  assign out_o.last       = last_q;

endmodule

### hdl/lru_writeback_register_cache.sv
// top level of the lru writeback register cache
// depends on rwrc_pkg, rwrc_in_if, rwrc_out_if, rwrc_front, rwrc_back and the defines header
//
// usage:
//   in_i carries one request per item: let (mode 0), load (1), store (2), flush (3).
//   out_o returns a short run of results per request; the final one has last set.
//   requests enter a two-entry queue in the front part; the back part takes one
//   request at a time from that queue.
// sequencing:
//   a request without writeback passes the back part as tag match, then decide with
//   recency update and result; a writeback adds a final state that gives the result after it.
//   flush scans the entries one per cycle (a dirty entry waits for the output register).
// reset:
//   all entries empty and clean, recency order 0 .. NUM_REGS-1, queue empty.
// stall:
//   results sit in an output register until taken; the back part then waits,
//   the queue fills and in_i.ready drops once it holds two requests.
`include "lru_writeback_register_cache_defines.svh"

module lru_writeback_register_cache import rwrc_pkg::*; #(
  parameter int unsigned NUM_REGS    = 8,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rwrc_in_if.sink    in_i,
  rwrc_out_if.source out_o
);

  desc_t desc;
  logic  desc_valid, desc_ready;

  // request intake and queue
  rwrc_front #(
    .NUM_REGS (NUM_REGS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .desc_o       (desc),
    .desc_valid_o (desc_valid),
    .desc_ready_i (desc_ready)
  );

  // cache state and result sequencing
  rwrc_back #(
    .NUM_REGS    (NUM_REGS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (desc),
    .desc_valid_i (desc_valid),
    .desc_ready_o (desc_ready),
    .out_o        (out_o)
  );

  // checks
  `RWRC_ASSERT(a_err_is_last, !(out_o.valid && out_o.action == ACT_ERR) || out_o.last)
  `RWRC_ASSERT(a_wb_not_last, !(out_o.valid && out_o.action == ACT_WB) || !out_o.last)
  `RWRC_ASSERT(a_value_only_set,
    !(out_o.valid && out_o.action != ACT_SET) || (out_o.value_out == '0))
  `RWRC_ASSERT_NEXT(a_back_busy_after_take, desc_valid && desc_ready, !desc_ready)

endmodule
